[rtl/tpf_pkg.sv]
`timescale 1ns / 1ps
package tpf_pkg;

    localparam int SLOT_COUNT          = 4;
    localparam int DEF_NUM_PREDICATES  = 4;
    localparam int DEF_VALUE_BITS      = 64;
    localparam int ATTR_BITS           = 64;
    localparam int CTRL_SLOT_BITS      = 13;
    localparam int CTRL_BITS           = 52;

    // operator codes
    localparam logic [2:0] OP_EQ = 3'd0;
    localparam logic [2:0] OP_NE = 3'd1;
    localparam logic [2:0] OP_LT = 3'd2;
    localparam logic [2:0] OP_LE = 3'd3;
    localparam logic [2:0] OP_GT = 3'd4;
    localparam logic [2:0] OP_GE = 3'd5;

    // type tags
    localparam logic [1:0] TY_INT  = 2'd0;
    localparam logic [1:0] TY_DBL  = 2'd1;
    localparam logic [1:0] TY_STR  = 2'd2;
    localparam logic [1:0] TY_BOOL = 2'd3;

    // compare outcome
    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;
    localparam logic [1:0] CMP_UN = 2'd3;

    // register indexes
    localparam logic [2:0] REG_COUNT    = 3'd0;
    localparam logic [2:0] REG_CONTROLS = 3'd1;
    localparam logic [2:0] REG_VALUE_A  = 3'd2;
    localparam logic [2:0] REG_VALUE_B  = 3'd3;
    localparam logic [2:0] REG_VALUE_C  = 3'd4;
    localparam logic [2:0] REG_VALUE_D  = 3'd5;

    typedef struct packed {
        logic                 valid;
        logic [7:0]           idx;
        logic [1:0]           ty;
        logic [ATTR_BITS-1:0] bits;
        logic                 last;
        logic                 match;
    } t_beat;

    typedef struct packed {
        logic                 active;
        logic [7:0]           idx;
        logic [2:0]           op;
        logic [1:0]           ty;
        logic [ATTR_BITS-1:0] value;
    } t_slot_cfg;

    // string compare: bytes from the top, stop where both hold nul
    function automatic logic [1:0] cmp_str(input logic [63:0] a, input logic [63:0] b);
        logic [1:0] res;
        logic [7:0] ca;
        logic [7:0] cb;
        res = CMP_EQ;
        for (int i = 0; i < 8; i++) begin
            ca = a[8*i +: 8];
            cb = b[8*i +: 8];
            if (ca != cb) begin
                res = (ca < cb) ? CMP_LT : CMP_GT;
            end else if (ca == 8'd0) begin
                res = CMP_EQ;
            end
        end
        return res;
    endfunction

    function automatic logic [1:0] cmp_dbl(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ka;
        logic [63:0] kb;
        logic        nan_a;
        logic        nan_b;
        nan_a = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
        nan_b = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
        ka = a[63] ? ~a : (a ^ 64'h8000_0000_0000_0000);
        kb = b[63] ? ~b : (b ^ 64'h8000_0000_0000_0000);
        if (nan_a || nan_b) begin
            return CMP_UN;
        end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
            return CMP_EQ;
        end else if (ka < kb) begin
            return CMP_LT;
        end else if (ka > kb) begin
            return CMP_GT;
        end
        return CMP_EQ;
    endfunction

endpackage

[rtl/tpf_cell.sv]
`timescale 1ns / 1ps
module tpf_cell import tpf_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_slot_cfg i_cfg,
    input  t_beat     i_beat,
    output t_beat     o_beat
);

    localparam int SHIFT = ATTR_BITS - VALUE_BITS;

    t_beat       r_beat;
    logic        r_hit;
    logic        n_hit;
    logic [1:0]  cmp;
    logic        chk;
    logic signed [ATTR_BITS-1:0] int_a;
    logic signed [ATTR_BITS-1:0] int_b;

    // integers live in the low VALUE_BITS; shift up so the sign sits on top
    assign int_a = $signed(i_beat.bits << SHIFT);
    assign int_b = $signed(i_cfg.value << SHIFT);

    always_comb begin
        case (i_beat.ty)
            TY_INT:  cmp = (int_a < int_b) ? CMP_LT : ((int_a > int_b) ? CMP_GT : CMP_EQ);
            TY_DBL:  cmp = cmp_dbl(i_beat.bits, i_cfg.value);
            TY_STR:  cmp = cmp_str(i_beat.bits, i_cfg.value);
            default: cmp = ((i_beat.bits != '0) == (i_cfg.value != '0)) ? CMP_EQ : CMP_GT;
        endcase
    end

    always_comb begin
        chk = 1'b0;
        if (i_cfg.idx == i_beat.idx) begin
            if (i_cfg.ty != i_beat.ty) begin
                chk = (i_cfg.op == OP_NE);
            end else begin
                case (i_cfg.op)
                    OP_EQ: chk = (cmp == CMP_EQ);
                    OP_NE: chk = (cmp != CMP_EQ);
                    OP_LT: chk = (i_beat.ty != TY_BOOL) && (cmp == CMP_LT);
                    OP_LE: chk = (i_beat.ty != TY_BOOL) && (cmp inside {CMP_LT, CMP_EQ});
                    OP_GT: chk = (i_beat.ty != TY_BOOL) && (cmp == CMP_GT);
                    OP_GE: chk = (i_beat.ty != TY_BOOL) && (cmp inside {CMP_GT, CMP_EQ});
                    default: chk = 1'b0;
                endcase
            end
        end
    end

    assign n_hit = r_hit | chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat.valid <= i_beat.valid;
            if (i_beat.valid) begin
                r_hit <= i_beat.last ? 1'b0 : n_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat.idx   <= i_beat.idx;
            r_beat.ty    <= i_beat.ty;
            r_beat.bits  <= i_beat.bits;
            r_beat.last  <= i_beat.last;
            r_beat.match <= i_beat.match & (~i_cfg.active | n_hit);
        end
    end

    assign o_beat = r_beat;

endmodule

[rtl/tuple_predicate_filter_top.sv]
`timescale 1ns / 1ps
// tuple predicate filter
// attributes of a tuple stream in on the input channel, one beat each; the
// beat with attr_last closes the tuple and produces one beat on the output
// channel whose tuple_match says whether every active predicate held
// configuration beats on the cfg channel are always taken (cfg_ready tied high);
// the user must write only while no tuple is in flight, the block does not check
// the attribute walks a row of cells, one per slot up to NUM_PREDICATES; each cell
// compares it against its own slot, keeps its hit bit for the tuple and
// folds its verdict into the running match carried with the closing beat
// path: the first cell captures an attribute at the accepting edge, each
// later cell takes it from the one before, and the output register takes
// the closing beat from the last cell
// throughput: one attribute per cycle; the row and the output register all
// advance together, so a stalled receiver holds the whole row and drops
// in_ready until the output beat is taken
// reset clears the count, controls and constants, all hit bits and the
// valid bits of the row; no clearing pass is needed
module tuple_predicate_filter_top import tpf_pkg::*; #(
    parameter int NUM_PREDICATES = DEF_NUM_PREDICATES,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_attr_index,
    input  logic [1:0]           i_attr_type,
    input  logic [ATTR_BITS-1:0] i_attr_bits,
    input  logic                 i_attr_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_tuple_match,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [ATTR_BITS-1:0] i_cfg_data
);

    // cells beyond the number of slots could never be active
    localparam int NCELL = (NUM_PREDICATES < SLOT_COUNT) ? NUM_PREDICATES : SLOT_COUNT;

    logic [2:0]           r_count;
    logic [CTRL_BITS-1:0] r_ctrl;
    logic [ATTR_BITS-1:0] r_value [SLOT_COUNT];
    logic [2:0]           n_active;
    logic                 en;
    logic                 r_out_valid;
    logic                 r_match;
    t_beat                beat [NCELL+1];
    t_slot_cfg            slot_cfg [NCELL];

    // register file; the user must write only while idle, the block does not check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ctrl  <= '0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_value[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COUNT:    r_count    <= i_cfg_data[2:0];
                REG_CONTROLS: r_ctrl     <= i_cfg_data[CTRL_BITS-1:0];
                REG_VALUE_A:  r_value[0] <= i_cfg_data;
                REG_VALUE_B:  r_value[1] <= i_cfg_data;
                REG_VALUE_C:  r_value[2] <= i_cfg_data;
                REG_VALUE_D:  r_value[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // saturate the count to the number of cells
    assign n_active = (r_count > 3'(NCELL)) ? 3'(NCELL) : r_count;

    // whole row moves when the output register can take a beat
    assign en         = ~r_out_valid | i_out_ready;
    assign o_in_ready = en;

    always_comb begin
        beat[0].valid = i_in_valid;
        beat[0].idx   = i_attr_index;
        beat[0].ty    = i_attr_type;
        beat[0].bits  = i_attr_bits;
        beat[0].last  = i_attr_last;
        beat[0].match = 1'b1;
    end

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        always_comb begin
            slot_cfg[k].active = (3'(k) < n_active);
            slot_cfg[k].idx    = r_ctrl[CTRL_SLOT_BITS*k +: 8];
            slot_cfg[k].op     = r_ctrl[CTRL_SLOT_BITS*k + 8 +: 3];
            slot_cfg[k].ty     = r_ctrl[CTRL_SLOT_BITS*k + 11 +: 2];
            slot_cfg[k].value  = r_value[k];
        end

        tpf_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cfg   (slot_cfg[k]),
            .i_beat  (beat[k]),
            .o_beat  (beat[k+1])
        );
    end

    // output register, only closing beats become results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= beat[NCELL].valid & beat[NCELL].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_match <= beat[NCELL].match;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tuple_match = r_match;

endmodule

[rtl/tpf_checker.sv]
`timescale 1ns / 1ps
module tpf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_tuple_match
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tuple_match))
        else $error("result changed while stalled");

    // a stalled result blocks intake
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // an empty output register never blocks intake
    a_free_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input refused with empty output");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

endmodule

bind tuple_predicate_filter_top tpf_checker u_tpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_tuple_match (o_tuple_match)
);

[tb/tb_tuple_predicate_filter_top.sv]
`timescale 1ns / 1ps
module tb_tuple_predicate_filter_top;
    import tpf_pkg::*;

    localparam int PIPE_SETTLE = 10;   // row of cells plus output register, with margin
    localparam int STALL_LIMIT = 3000;
    localparam int CALM_TAIL   = 150;

    typedef enum logic [1:0] {K_ATTR, K_CFG, K_DRAIN} t_kind;

    typedef struct {
        t_kind                kind;
        logic [7:0]           idx;
        logic [1:0]           ty;
        logic [ATTR_BITS-1:0] bits;
        logic                 last;
        logic [2:0]           reg_idx;
        logic [ATTR_BITS-1:0] data;
    } t_job;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_attr_index;
    logic [1:0]           i_attr_type;
    logic [ATTR_BITS-1:0] i_attr_bits;
    logic                 i_attr_last;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_tuple_match;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_index;
    logic [ATTR_BITS-1:0] i_cfg_data;

    tuple_predicate_filter_top u_top (.*);

    // jobs still to drive, and the match bits still owed by the block
    t_job job_q[$];
    logic match_q[$];
    int   errors;

    // shadow of the block's registers and hit bits
    logic [2:0]           sh_count;
    logic [CTRL_BITS-1:0] sh_ctrl;
    logic [ATTR_BITS-1:0] sh_value [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] sh_hits;

    // copy of the constants as the stimulus builder last wrote them
    logic [ATTR_BITS-1:0] gen_value [SLOT_COUNT];

    int  gap;
    int  stall;
    int  settle;
    int  idle_cycles;

    always #5 i_clk = ~i_clk;

    function automatic logic [1:0] order_of(input logic [1:0] ty, input logic [63:0] a,
                                            input logic [63:0] b);
        real x;
        real y;
        case (ty)
            TY_INT: begin
                if ($signed(a) < $signed(b)) return CMP_LT;
                if ($signed(a) > $signed(b)) return CMP_GT;
                return CMP_EQ;
            end
            TY_DBL: begin
                x = $bitstoreal(a);
                y = $bitstoreal(b);
                if (x < y) return CMP_LT;
                if (x > y) return CMP_GT;
                if (x == y) return CMP_EQ;
                return CMP_UN;
            end
            TY_STR: begin
                for (int i = 7; i >= 0; i--) begin
                    if (a[8*i +: 8] != b[8*i +: 8])
                        return (a[8*i +: 8] < b[8*i +: 8]) ? CMP_LT : CMP_GT;
                    if (a[8*i +: 8] == 8'd0) return CMP_EQ;
                end
                return CMP_EQ;
            end
            default: return ((a != 0) == (b != 0)) ? CMP_EQ : CMP_GT;
        endcase
    endfunction

    function automatic logic slot_holds(input int k, input logic [7:0] idx,
                                        input logic [1:0] ty, input logic [63:0] bits);
        logic [12:0] ctl;
        logic [2:0]  op;
        logic [1:0]  c;
        ctl = sh_ctrl[13*k +: 13];
        op  = ctl[10:8];
        if (ctl[7:0] != idx) return 1'b0;
        if (op > OP_GE) return 1'b0;
        if (ctl[12:11] != ty) return op == OP_NE;
        c = order_of(ty, bits, sh_value[k]);
        if (op == OP_EQ) return c == CMP_EQ;
        if (op == OP_NE) return c != CMP_EQ;
        if (ty == TY_BOOL || c == CMP_UN) return 1'b0;
        case (op)
            OP_LT:   return c == CMP_LT;
            OP_LE:   return c == CMP_LT || c == CMP_EQ;
            OP_GT:   return c == CMP_GT;
            default: return c == CMP_GT || c == CMP_EQ;
        endcase
    endfunction

    // fold one accepted attribute beat into the hit bits; closing beat owes a match
    task automatic absorb_attr(input logic [7:0] idx, input logic [1:0] ty,
                               input logic [63:0] bits, input logic last);
        int n;
        logic [SLOT_COUNT-1:0] mask;
        for (int k = 0; k < SLOT_COUNT; k++)
            if (slot_holds(k, idx, ty, bits)) sh_hits[k] = 1'b1;
        if (last) begin
            n = (sh_count > SLOT_COUNT) ? SLOT_COUNT : sh_count;
            mask = SLOT_COUNT'((1 << n) - 1);
            match_q.push_back((sh_hits & mask) == mask);
            sh_hits = '0;
        end
    endtask

    task automatic add_attr(input logic [7:0] idx, input logic [1:0] ty,
                            input logic [63:0] bits, input logic last);
        t_job j;
        j = '{kind: K_ATTR, idx: idx, ty: ty, bits: bits, last: last, reg_idx: 3'd0, data: '0};
        job_q.push_back(j);
    endtask

    task automatic add_cfg(input logic [2:0] r, input logic [63:0] d);
        t_job j;
        j = '{kind: K_CFG, idx: 8'd0, ty: TY_INT, bits: '0, last: 1'b0, reg_idx: r, data: d};
        job_q.push_back(j);
        if (r >= REG_VALUE_A && r <= REG_VALUE_D) gen_value[r - REG_VALUE_A] = d;
    endtask

    task automatic add_drain();
        t_job j;
        j = '{kind: K_DRAIN, idx: 8'd0, ty: TY_INT, bits: '0, last: 1'b0, reg_idx: 3'd0,
              data: '0};
        job_q.push_back(j);
    endtask

    function automatic logic [12:0] slot_word(input logic [7:0] idx, input logic [2:0] op,
                                              input logic [1:0] ty);
        return {ty, op, idx};
    endfunction

    // values that land near the constants and on the edges of each type
    function automatic logic [63:0] pick_value(input logic [1:0] ty);
        logic [63:0] s;
        if ($urandom_range(0, 3) == 0) return gen_value[$urandom_range(0, 3)];
        case (ty)
            TY_INT: case ($urandom_range(0, 5))
                0: return 64'd0;
                1: return '1;
                2: return 64'h7fff_ffff_ffff_ffff;
                3: return 64'h8000_0000_0000_0000;
                4: return 64'($signed($urandom_range(0, 8)) - 4);
                default: return {$urandom, $urandom};
            endcase
            TY_DBL: case ($urandom_range(0, 6))
                0: return 64'h0000_0000_0000_0000;
                1: return 64'h8000_0000_0000_0000;
                2: return 64'h7ff8_0000_0000_0001;
                3: return 64'hfff0_0000_0000_0000;
                4: return 64'h7ff0_0000_0000_0000;
                5: return $realtobits(real'($signed($urandom_range(0, 8)) - 4) / 2.0);
                default: return {$urandom, $urandom};
            endcase
            TY_STR: begin
                s = '0;
                for (int i = 7; i >= 8 - int'($urandom_range(0, 8)); i--)
                    s[8*i +: 8] = ($urandom_range(0, 7) == 0)
                                  ? 8'hff : 8'h61 + 8'($urandom_range(0, 2));
                // stray bytes behind the terminator must not matter
                if ($urandom_range(0, 3) == 0) s[7:0] = 8'($urandom);
                return s;
            end
            default: case ($urandom_range(0, 2))
                0: return 64'd0;
                1: return 64'd1;
                default: return {$urandom, $urandom};
            endcase
        endcase
    endfunction

    // sender: one job at a time from job_q, configuration only once the row is empty
    always @(posedge i_clk) begin : driver
        logic in_busy;
        logic cfg_busy;
        logic in_next;
        logic cfg_next;
        logic drained;
        t_job j;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            settle = 0;
            gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                absorb_attr(i_attr_index, i_attr_type, i_attr_bits, i_attr_last);
                settle = 0;
            end else if (settle < PIPE_SETTLE) begin
                settle++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_COUNT:    sh_count = i_cfg_data[2:0];
                    REG_CONTROLS: sh_ctrl  = i_cfg_data[CTRL_BITS-1:0];
                    REG_VALUE_A, REG_VALUE_B, REG_VALUE_C, REG_VALUE_D:
                        sh_value[i_cfg_index - REG_VALUE_A] = i_cfg_data;
                    default: ;   // writes beyond the last register are dropped
                endcase
            end
            in_busy  = i_in_valid && !o_in_ready;
            cfg_busy = i_cfg_valid && !o_cfg_ready;
            in_next  = in_busy;
            cfg_next = cfg_busy;
            drained  = match_q.size() == 0 && settle >= PIPE_SETTLE && !i_in_valid;
            if (gap > 0) gap--;
            if (!in_busy && !cfg_busy && job_q.size() > 0) begin
                j = job_q[0];
                if (j.kind == K_ATTR && gap == 0) begin
                    void'(job_q.pop_front());
                    i_attr_index <= j.idx;
                    i_attr_type  <= j.ty;
                    i_attr_bits  <= j.bits;
                    i_attr_last  <= j.last;
                    in_next = 1'b1;
                    if (job_q.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                        gap = $urandom_range(1, 6);
                end else if (j.kind == K_CFG && drained) begin
                    void'(job_q.pop_front());
                    i_cfg_index <= j.reg_idx;
                    i_cfg_data  <= j.data;
                    cfg_next = 1'b1;
                end else if (j.kind == K_DRAIN && drained) begin
                    void'(job_q.pop_front());
                end
            end
            i_in_valid  <= in_next;
            i_cfg_valid <= cfg_next;
        end
    end

    // receiver: random stall bursts, compare each match beat with the oldest owed
    always @(posedge i_clk) begin : monitor
        logic want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (match_q.size() == 0) begin
                    $display("%0t: unexpected match beat, expected none, actual %0b",
                             $time, o_tuple_match);
                    errors++;
                end else begin
                    want = match_q.pop_front();
                    if (o_tuple_match !== want) begin
                        $display("%0t: tuple_match expected %0b actual %0b",
                                 $time, want, o_tuple_match);
                        errors++;
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (job_q.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
                    stall = $urandom_range(1, 6);
            end
        end
    end

    // watchdog on beats of any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready)
                || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int attrs;
        int phase;
        int len;
        logic [CTRL_BITS-1:0] ctl;
        logic [1:0] slot_ty [SLOT_COUNT];
        logic [7:0] pidx;
        logic [1:0] pty;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_out_ready = 1'b0;
        i_attr_index = '0;
        i_attr_type = TY_INT;
        i_attr_bits = '0;
        i_attr_last = 1'b0;
        i_cfg_index = REG_COUNT;
        i_cfg_data = '0;
        errors = 0;
        idle_cycles = 0;
        sh_count = '0;
        sh_ctrl = '0;
        sh_hits = '0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            sh_value[k] = '0;
            gen_value[k] = '0;
        end

        // no predicates: any tuple matches
        add_cfg(REG_COUNT, 64'd0);
        add_attr(8'hff, TY_BOOL, '1, 1'b1);

        // one predicate per type: int >= -5, double < 2.5, string == "abc", bool != true
        add_cfg(REG_VALUE_A, 64'hffff_ffff_ffff_fffb);
        add_cfg(REG_VALUE_B, $realtobits(2.5));
        add_cfg(REG_VALUE_C, 64'h6162_6300_0000_0000);
        add_cfg(REG_VALUE_D, 64'd1);
        add_cfg(REG_CONTROLS, {slot_word(8'd3, OP_NE, TY_BOOL), slot_word(8'd2, OP_EQ, TY_STR),
                               slot_word(8'd1, OP_LT, TY_DBL), slot_word(8'd0, OP_GE, TY_INT)});
        add_cfg(REG_COUNT, 64'd4);
        // all hold; string junk after the terminator is ignored
        add_attr(8'd0, TY_INT, 64'hffff_ffff_ffff_fffb, 1'b0);
        add_attr(8'd1, TY_DBL, 64'h8000_0000_0000_0000, 1'b0);
        add_attr(8'd2, TY_STR, 64'h6162_6300_41ff_0000, 1'b0);
        add_attr(8'd3, TY_BOOL, 64'd0, 1'b1);
        // most negative integer, NaN, wrong type on the not-equal slot
        add_attr(8'd0, TY_INT, 64'h8000_0000_0000_0000, 1'b0);
        add_attr(8'd1, TY_DBL, 64'h7ff8_0000_0000_0000, 1'b0);
        add_attr(8'd3, TY_INT, 64'd5, 1'b1);
        // repeated attribute, later copy holds; string slot missing
        add_attr(8'd0, TY_INT, 64'h8000_0000_0000_0000, 1'b0);
        add_attr(8'd0, TY_INT, 64'h7fff_ffff_ffff_ffff, 1'b0);
        add_attr(8'd1, TY_DBL, 64'hfff0_0000_0000_0000, 1'b0);
        add_attr(8'd3, TY_BOOL, 64'd0, 1'b1);
        // oversized count saturates; all-ones controls give unknown operators
        add_cfg(REG_COUNT, 64'hffff_ffff_ffff_ffff);
        add_cfg(REG_CONTROLS, '1);
        add_attr(8'hff, TY_BOOL, '1, 1'b1);
        // writes past the last register change nothing
        add_cfg(3'd6, '1);
        add_cfg(3'd7, '1);
        add_attr(8'hff, TY_BOOL, 64'd0, 1'b1);

        // random phases: fresh settings, then well-formed tuples aimed at the slots
        attrs = 0;
        phase = 0;
        while (attrs < 1800) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                slot_ty[k] = 2'($urandom_range(0, 3));
                ctl[13*k +: 13] = slot_word(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                       : 8'($urandom_range(0, 4)),
                                            ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                                       : 3'($urandom_range(0, 5)),
                                            slot_ty[k]);
                add_cfg(3'(REG_VALUE_A + k), {$urandom, $urandom});
                add_cfg(3'(REG_VALUE_A + k), pick_value(slot_ty[k]));
            end
            add_cfg(REG_CONTROLS, {$urandom, $urandom});
            add_cfg(REG_CONTROLS, {12'($urandom), ctl});
            add_cfg(REG_COUNT, (phase == 0) ? 64'd0 : (phase == 1) ? 64'd4 : (phase == 2)
                               ? 64'hffff_ffff_ffff_ffff : 64'({$urandom, $urandom}));
            for (int t = 0; t < 40 && attrs < 1800; t++) begin
                len = $urandom_range(1, 6);
                for (int a = 0; a < len; a++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        pidx = 8'($urandom);
                        pty  = 2'($urandom);
                    end else begin
                        pidx = 8'($urandom_range(0, 4));
                        pty  = (pidx < SLOT_COUNT && $urandom_range(0, 4) != 0)
                               ? slot_ty[ctl[13*pidx +: 2] % SLOT_COUNT] : 2'($urandom);
                        for (int k = 0; k < SLOT_COUNT; k++)
                            if (ctl[13*k +: 8] == pidx && $urandom_range(0, 4) != 0)
                                pty = slot_ty[k];
                    end
                    add_attr(pidx, pty, pick_value(pty), a == len - 1);
                    attrs++;
                end
                // sender holds off until every owed match is back
                if ($urandom_range(0, 30) == 0) add_drain();
            end
            phase++;
        end
        add_drain();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() > 0 || i_in_valid || i_cfg_valid || match_q.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_SETTLE * 2) @(posedge i_clk);
        if (errors == 0 && match_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
